/* hw/rtl/ptd_pkg.sv */
// Shared types, constants and helper functions of the periodic task dispatcher.
`default_nettype none

package ptd_pkg;

	localparam int SETUP_REGS  = 4;
	localparam int SETUP_W     = 33;
	localparam int REG_IDX_W   = 3;
	localparam int FIRST_W     = 3;
	localparam int CORE_W      = 2;
	localparam int TIDX_W      = 2;
	localparam int GUARD_W     = 16;
	localparam int CNT_W       = 16;
	localparam int MARGIN_US   = 3;
	localparam int GUARD_MUL   = 100;
	localparam int GUARD_SHIFT = 7;

	// Register indexes of the write port
	localparam logic [REG_IDX_W-1:0] REG_TASK0_SETUP = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TASK1_SETUP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TASK2_SETUP = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TASK3_SETUP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CORE1_FIRST = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CORE2_FIRST = 3'd5;

	localparam logic [SETUP_W-1:0] SETUP_RESET [SETUP_REGS] = '{
		33'h1_0005_0001, 33'h1_0004_000A, 33'h0_0000_0000, 33'h0_0000_0000
	};
	localparam logic [FIRST_W-1:0] CORE1_FIRST_RESET = 3'd2;
	localparam logic [FIRST_W-1:0] CORE2_FIRST_RESET = 3'd3;

	typedef struct packed {
		logic               enable;
		logic [15:0]        wcet;
		logic [CNT_W-1:0]   period;
	} task_setup_t;

	typedef enum logic [2:0] {
		KIND_TICK_OK     = 3'd0,
		KIND_OVERRUN     = 3'd1,
		KIND_DISPATCH    = 3'd2,
		KIND_NOTHING_DUE = 3'd3,
		KIND_NOT_PENDING = 3'd4
	} result_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_WALK,
		ST_FIN
	} seq_state_t;

	// Countdown value of a task right after reset
	function automatic logic [CNT_W-1:0] reset_period(input logic [TIDX_W-1:0] idx);
		return SETUP_RESET[idx][CNT_W-1:0];
	endfunction

	// ceil((wcet + margin) * 100 / 128), clamped to 1..65535
	function automatic logic [GUARD_W-1:0] guard_of(input logic [15:0] wcet);
		logic [23:0] sum;
		logic [16:0] r;
		sum = (24'(wcet) + 24'(MARGIN_US)) * 24'(GUARD_MUL)
			+ 24'((1 << GUARD_SHIFT) - 1);
		r = 17'(sum >> GUARD_SHIFT);
		if (r == 17'd0) begin
			r = 17'd1;
		end
		if (r > 17'h0FFFF) begin
			r = 17'h0FFFF;
		end
		return r[GUARD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/periodic_task_dispatcher_core.sv */
// Top level of the periodic task dispatcher: configuration registers and stream ports.
`default_nettype none

// A tick item, or a run item for a core that is not pending, is accepted in
// the idle state, and the single state then loads its result into the output
// register. A run item for a pending core issues the first countdown read on
// acceptance if the core owns any task; the memory then does one
// read-modify-write per cycle while the walk is not stalled, over the tasks
// the core owns, and the closing state emits the last dispatch (or the
// nothing-due result) and clears the core's flag. Each result waits in the
// output register until taken; a dispatch that finds an earlier one still
// held stalls the walk while that register is full, and the single and
// closing states wait for it as well.
// Countdowns start from the reset periods of the task setups through
// per-entry valid bits, so there is no clearing pass after reset.
module periodic_task_dispatcher_core
	import ptd_pkg::*;
#(
	parameter int NUM_TASKS = 4,
	parameter int NUM_CORES = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [SETUP_W-1:0]   wr_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [1:0] core_id
	input  wire logic [0:0]           s_tuser,  // [0] req_type
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,  // [1:0] task_index, [17:2] guard_reload
	output logic [2:0]                m_tuser,  // [2:0] result_kind
	output logic                      m_tlast   // last_result
);

	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	task_setup_t        setup_q [SETUP_REGS];
	logic [FIRST_W-1:0] core1_first_q, core2_first_q;
	logic [CW-1:0]      c1_cl, c2_cl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SETUP_REGS; i++) begin
				setup_q[i] <= task_setup_t'(SETUP_RESET[i]);
			end
			core1_first_q <= CORE1_FIRST_RESET;
			core2_first_q <= CORE2_FIRST_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TASK0_SETUP: setup_q[0] <= task_setup_t'(wr_data);
				REG_TASK1_SETUP: setup_q[1] <= task_setup_t'(wr_data);
				REG_TASK2_SETUP: setup_q[2] <= task_setup_t'(wr_data);
				REG_TASK3_SETUP: setup_q[3] <= task_setup_t'(wr_data);
				REG_CORE1_FIRST: core1_first_q <= wr_data[FIRST_W-1:0];
				REG_CORE2_FIRST: core2_first_q <= wr_data[FIRST_W-1:0];
				default: ;
			endcase
		end
	end

	// Bounds above the task count behave as the task count
	assign c1_cl = (core1_first_q > FIRST_W'(NUM_TASKS)) ? CW'(NUM_TASKS) : CW'(core1_first_q);
	assign c2_cl = (core2_first_q > FIRST_W'(NUM_TASKS)) ? CW'(NUM_TASKS) : CW'(core2_first_q);

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [CNT_W-1:0] ram_wdata, ram_rdata;
	result_kind_t     out_kind;
	logic [TIDX_W-1:0]  out_idx;
	logic [GUARD_W-1:0] out_guard;

	ptd_cnt_ram #(
		.DEPTH (NUM_TASKS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ptd_seq #(
		.NUM_TASKS(NUM_TASKS),
		.NUM_CORES(NUM_CORES),
		.CW       (CW),
		.AW       (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.setup      (setup_q),
		.core1_first(c1_cl),
		.core2_first(c2_cl),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser[0]),
		.in_core    (s_tdata[CORE_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_idx    (out_idx),
		.out_guard  (out_guard),
		.out_last   (m_tlast),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	assign m_tdata = {6'd0, out_guard, out_idx};
	assign m_tuser = out_kind;

endmodule

`default_nettype wire

/* hw/rtl/ptd_cnt_ram.sv */
// Countdown memory: one write port, one registered read port, reset-valued until written.
`default_nettype none

module ptd_cnt_ram
	import ptd_pkg::*;
#(
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [CNT_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// An entry never written reads as the task's reset period
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : reset_period(TIDX_W'(raddr));
		end
	end

	assign rdata = rdata_q;

`ifndef NO_ASSERTIONS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("countdown read and write hit the same entry");
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(we || re) |-> ((32'(waddr) < DEPTH || !we) && (32'(raddr) < DEPTH || !re)))
		else $error("countdown access beyond depth");
	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> valid_q[$past(waddr)])
		else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ptd_seq.sv */
// Pass sequencer: pending flags, task walk with read-modify-write, result register.
`default_nettype none

module ptd_seq
	import ptd_pkg::*;
#(
	parameter int NUM_TASKS = 4,
	parameter int NUM_CORES = 3,
	parameter int CW = $clog2(NUM_TASKS + 1),
	parameter int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire task_setup_t      setup [SETUP_REGS],
	input  wire logic [CW-1:0]    core1_first,
	input  wire logic [CW-1:0]    core2_first,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_req,
	input  wire logic [CORE_W-1:0] in_core,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output result_kind_t          out_kind,
	output logic [TIDX_W-1:0]     out_idx,
	output logic [GUARD_W-1:0]    out_guard,
	output logic                  out_last,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [CNT_W-1:0]      ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr,
	input  wire logic [CNT_W-1:0] ram_rdata
);

	localparam int PW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

	seq_state_t           state_q, state_d;
	logic [CORE_W-1:0]    core_q;
	logic [CW-1:0]        t_q, hi_q;
	result_kind_t         kind_q;
	logic                 held_v_q;
	logic [TIDX_W-1:0]    held_idx_q;
	logic [GUARD_W-1:0]   held_guard_q;
	logic                 out_v_q;
	result_kind_t         out_kind_q;
	logic [TIDX_W-1:0]    out_idx_q;
	logic [GUARD_W-1:0]   out_guard_q;
	logic                 out_last_q;
	logic [NUM_CORES-1:0] pending_q;

	logic                 in_fire, core_ok, is_tick, cur_pending;
	logic [PW-1:0]        cidx, cidx_q;
	logic [CW-1:0]        c2_eff, lo, hi, t_nx;
	logic                 out_free;
	task_setup_t          cur;
	logic [CNT_W-1:0]     dec;
	logic                 disp, step_ok, walk_end;
	logic [GUARD_W-1:0]   cur_guard;
	logic                 push;
	result_kind_t         push_kind;
	logic [TIDX_W-1:0]    push_idx;
	logic [GUARD_W-1:0]   push_guard;
	logic                 push_last;

	assign in_fire     = in_valid && in_ready;
	assign core_ok     = in_core < CORE_W'(NUM_CORES);
	assign is_tick     = !in_req;
	assign cidx        = PW'(in_core);
	assign cidx_q      = PW'(core_q);
	assign cur_pending = pending_q[cidx];
	assign out_free    = !out_v_q || out_ready;

	// Owned range of the addressed core: core 1 owns nothing if its bounds cross
	assign c2_eff = (core2_first > core1_first) ? core2_first : core1_first;
	always_comb begin
		case (in_core)
			2'd0: begin
				lo = '0;
				hi = core1_first;
			end
			2'd1: begin
				lo = core1_first;
				hi = c2_eff;
			end
			default: begin
				lo = c2_eff;
				hi = CW'(NUM_TASKS);
			end
		endcase
	end

	// Modify stage of the walk: countdown from memory, setup of the current task
	assign cur       = setup[TIDX_W'(t_q)];
	assign dec       = (ram_rdata != '0) ? ram_rdata - 1'b1 : ram_rdata;
	assign disp      = cur.enable && (dec == '0);
	assign cur_guard = guard_of(cur.wcet);
	assign step_ok   = !(disp && held_v_q) || out_free;
	assign t_nx      = t_q + 1'b1;
	assign walk_end  = (t_nx == hi_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && core_ok) begin
					if (is_tick || !cur_pending) begin
						state_d = ST_SINGLE;
					end else if (lo < hi) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (step_ok && walk_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = AW'(t_q);
		ram_wdata  = disp ? cur.period : dec;
		ram_re     = 1'b0;
		ram_raddr  = AW'(t_nx);
		push       = 1'b0;
		push_kind  = KIND_DISPATCH;
		push_idx   = held_idx_q;
		push_guard = held_guard_q;
		push_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_re    = in_fire && core_ok && in_req && cur_pending && (lo < hi);
				ram_raddr = AW'(lo);
			end
			ST_SINGLE: begin
				push       = out_free;
				push_kind  = kind_q;
				push_idx   = '0;
				push_guard = '0;
				push_last  = 1'b1;
			end
			ST_WALK: begin
				ram_we = step_ok && cur.enable;
				ram_re = step_ok && !walk_end;
				// a new dispatch releases the one held before it
				push   = step_ok && disp && held_v_q;
			end
			ST_FIN: begin
				push      = out_free;
				push_last = 1'b1;
				if (!held_v_q) begin
					push_kind  = KIND_NOTHING_DUE;
					push_idx   = '0;
					push_guard = '0;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_v_q   <= 1'b0;
			held_v_q  <= 1'b0;
			pending_q <= '0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_fire && core_ok) begin
				held_v_q <= 1'b0;
				if (is_tick) begin
					pending_q[cidx] <= 1'b1;
				end
			end
			if (state_q == ST_WALK && step_ok && disp) begin
				held_v_q <= 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				pending_q[cidx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q  <= push_kind;
			out_idx_q   <= push_idx;
			out_guard_q <= push_guard;
			out_last_q  <= push_last;
		end
		if (state_q == ST_IDLE && in_fire) begin
			core_q <= in_core;
			t_q    <= lo;
			hi_q   <= hi;
			if (is_tick) begin
				kind_q <= cur_pending ? KIND_OVERRUN : KIND_TICK_OK;
			end else begin
				kind_q <= KIND_NOT_PENDING;
			end
		end
		if (state_q == ST_WALK && step_ok) begin
			t_q <= t_nx;
			if (disp) begin
				held_idx_q   <= TIDX_W'(t_q);
				held_guard_q <= cur_guard;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_kind  = out_kind_q;
	assign out_idx   = out_idx_q;
	assign out_guard = out_guard_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (t_q < hi_q) && (32'(t_q) < NUM_TASKS))
		else $error("walk index outside the owned range");
	a_held_only_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> (state_q == ST_WALK || state_q == ST_FIN || state_q == ST_IDLE))
		else $error("held dispatch outside a pass");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over an untaken one");
	a_tick_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && core_ok && is_tick) |=> pending_q[$past(cidx)])
		else $error("tick did not leave core pending");
	a_fin_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> !pending_q[$past(cidx_q)])
		else $error("run pass did not clear pending");
`endif

endmodule

`default_nettype wire

/* bench/periodic_task_dispatcher_core_test.sv */
// Self-checking testbench of the periodic task dispatcher core.
`timescale 1ns / 100ps

module periodic_task_dispatcher_core_test;
	import ptd_pkg::*;

	localparam int TB_TASKS = 4;
	localparam int CORE_COUNT = 3;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

	localparam logic [CORE_W-1:0] CORE_NONE = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		result_kind_t        kind;
		logic [TIDX_W-1:0]   idx;
		logic [GUARD_W-1:0]  guard;
		logic                last;
	} sched_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [SETUP_W-1:0]   wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;  // [1:0] core_id
	logic [0:0]           s_tuser;  // [0] req_type
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;  // [1:0] task_index, [17:2] guard_reload
	logic [2:0]           m_tuser;  // [2:0] result_kind
	logic                 m_tlast;

	// shadow of the scheduler state
	logic [SETUP_W-1:0] setup_shadow [TB_TASKS];
	logic [FIRST_W-1:0] core1_first;
	logic [FIRST_W-1:0] core2_first;
	logic               tick_flag [CORE_COUNT];
	logic [CNT_W-1:0]   countdown [TB_TASKS];

	sched_result_t sched_results [$];

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	periodic_task_dispatcher_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [GUARD_W-1:0] guard_reload(input logic [15:0] wcet);
		longint g;
		// round up (wcet + margin) * 100 / 128
		g = ((longint'(wcet) + 3) * 100 + 127) / 128;
		if (g < 1) begin
			g = 1;
		end
		if (g > 65535) begin
			g = 65535;
		end
		return g[GUARD_W-1:0];
	endfunction

	function automatic int owner_core(input int t);
		int c1;
		int c2;
		c1 = (core1_first > TB_TASKS) ? TB_TASKS : int'(core1_first);
		c2 = (core2_first > TB_TASKS) ? TB_TASKS : int'(core2_first);
		if (t < c1) begin
			return 0;
		end
		if (t < c2) begin
			return 1;
		end
		return 2;
	endfunction

	// Advance the shadow state by one item and queue the results it causes.
	function automatic void schedule_item(input logic req, input logic [CORE_W-1:0] core);
		sched_result_t r;
		logic          due [TB_TASKS];
		int            last_t;
		task_setup_t   s;
		last_t = -1;
		r = '{kind: KIND_TICK_OK, idx: '0, guard: '0, last: 1'b1};
		if (core >= CORE_COUNT) begin
			return;
		end
		if (req == REQ_TICK) begin
			r.kind = tick_flag[core] ? KIND_OVERRUN : KIND_TICK_OK;
			tick_flag[core] = 1'b1;
			sched_results.push_back(r);
			return;
		end
		if (!tick_flag[core]) begin
			r.kind = KIND_NOT_PENDING;
			sched_results.push_back(r);
			return;
		end
		for (int t = 0; t < TB_TASKS; t++) begin
			s = setup_shadow[t];
			due[t] = 1'b0;
			if (owner_core(t) == int'(core) && s.enable) begin
				if (countdown[t] != 0) begin
					countdown[t] = countdown[t] - 1'b1;
				end
				if (countdown[t] == 0) begin
					countdown[t] = s.period;
					due[t] = 1'b1;
					last_t = t;
				end
			end
		end
		tick_flag[core] = 1'b0;
		if (last_t < 0) begin
			r.kind = KIND_NOTHING_DUE;
			sched_results.push_back(r);
			return;
		end
		for (int t = 0; t < TB_TASKS; t++) begin
			if (due[t]) begin
				s = setup_shadow[t];
				r.kind = KIND_DISPATCH;
				r.idx = TIDX_W'(t);
				r.guard = guard_reload(s.wcet);
				r.last = (t == last_t);
				sched_results.push_back(r);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_result();
		sched_result_t want;
		if (sched_results.size() == 0) begin
			report_mismatch("result with nothing scheduled, kind", m_tuser, -1);
			return;
		end
		want = sched_results.pop_front();
		if (m_tuser !== want.kind) begin
			report_mismatch("result_kind", m_tuser, want.kind);
		end
		if (m_tdata[1:0] !== want.idx) begin
			report_mismatch("task_index", m_tdata[1:0], want.idx);
		end
		if (m_tdata[17:2] !== want.guard) begin
			report_mismatch("guard_reload", m_tdata[17:2], want.guard);
		end
		if (m_tlast !== want.last) begin
			report_mismatch("last_result", m_tlast, want.last);
		end
	endtask

	// Receiver: take results, stall at random or for a counted hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				check_result();
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic req, input logic [CORE_W-1:0] core);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {6'd0, core};
		do begin
			@(posedge clk);
		end while (!s_tready);
		schedule_item(req, core);
	endtask

	// Drop valid, drain all results, then let a walk with no result finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sched_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SETUP_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TASK0_SETUP, REG_TASK1_SETUP, REG_TASK2_SETUP, REG_TASK3_SETUP: begin
				setup_shadow[idx] = value;
			end
			REG_CORE1_FIRST: begin
				core1_first = value[FIRST_W-1:0];
			end
			REG_CORE2_FIRST: begin
				core2_first = value[FIRST_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic [SETUP_W-1:0] pick_setup();
		task_setup_t s;
		s.enable = ($urandom_range(99) < 80);
		case ($urandom_range(9))
			0: s.period = '0;
			1: s.period = 16'hFFFF;
			2: s.period = CNT_W'($urandom);
			default: s.period = CNT_W'($urandom_range(1, 4));
		endcase
		case ($urandom_range(5))
			0: s.wcet = '0;
			1: s.wcet = 16'hFFFF;
			default: s.wcet = 16'($urandom);
		endcase
		return s;
	endfunction

	function automatic logic [SETUP_W-1:0] pick_first();
		if ($urandom_range(3) == 0) begin
			return SETUP_W'($urandom_range(7));
		end
		return SETUP_W'($urandom_range(TB_TASKS));
	endfunction

	task automatic randomize_schedule();
		for (int i = 0; i < TB_TASKS; i++) begin
			write_reg(REG_TASK0_SETUP + REG_IDX_W'(i), pick_setup());
		end
		write_reg(REG_CORE1_FIRST, pick_first());
		write_reg(REG_CORE2_FIRST, pick_first());
	endtask

	// Reset setup: task 0 due on every core 0 pass, cores 1 and 2 own one disabled task each.
	task automatic test_reset_schedule();
		send_item(REQ_RUN,  2'd0);
		send_item(REQ_TICK, 2'd0);
		send_item(REQ_TICK, 2'd0);
		send_item(REQ_RUN,  2'd0);
		send_item(REQ_RUN,  2'd1);
		send_item(REQ_TICK, 2'd1);
		send_item(REQ_RUN,  2'd1);
		send_item(REQ_TICK, CORE_NONE);
		send_item(REQ_RUN,  CORE_NONE);
		send_item(REQ_TICK, 2'd2);
		send_item(REQ_RUN,  2'd2);
		settle();
	endtask

	// Extreme periods and wcets, ownership edges, spare register indexes.
	task automatic test_extremes();
		write_reg(REG_TASK0_SETUP, {1'b1, 16'h0000, 16'h0000});
		write_reg(REG_TASK1_SETUP, {1'b1, 16'hFFFF, 16'hFFFF});
		write_reg(REG_TASK2_SETUP, {1'b1, 16'h0001, 16'h0002});
		write_reg(REG_TASK3_SETUP, {1'b0, 16'h1234, 16'h0000});
		write_reg(REG_CORE1_FIRST, 33'd0);
		write_reg(REG_CORE2_FIRST, 33'd4);
		write_reg(REG_SPARE_A, {SETUP_W{1'b1}});
		write_reg(REG_SPARE_B, 33'h0_5555_5555);
		for (int i = 0; i < 3; i++) begin
			send_item(REQ_TICK, 2'd1);
			send_item(REQ_RUN,  2'd1);
		end
		settle();
		write_reg(REG_TASK3_SETUP, {1'b1, 16'hFFFF, 16'h0000});
		write_reg(REG_CORE1_FIRST, 33'd7);
		write_reg(REG_CORE2_FIRST, 33'd7);
		send_item(REQ_TICK, 2'd0);
		send_item(REQ_RUN,  2'd0);
		send_item(REQ_TICK, 2'd2);
		send_item(REQ_RUN,  2'd2);
		settle();
		// core 2 starts at or below core 1, so core 1 owns nothing
		write_reg(REG_CORE1_FIRST, 33'd3);
		write_reg(REG_CORE2_FIRST, 33'd1);
		send_item(REQ_TICK, 2'd1);
		send_item(REQ_RUN,  2'd1);
		send_item(REQ_TICK, 2'd2);
		send_item(REQ_RUN,  2'd2);
		send_item(REQ_TICK, 2'd0);
		send_item(REQ_RUN,  2'd0);
		settle();
	endtask

	// Mostly tick-then-run pairs, the rest loose items including the unused core.
	task automatic test_random_traffic(input int count);
		int          n;
		logic        req;
		logic [CORE_W-1:0] core;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 65) begin
				core = CORE_W'($urandom_range(CORE_COUNT - 1));
				send_item(REQ_TICK, core);
				send_item(REQ_RUN, core);
				n += 2;
			end else begin
				req  = 1'($urandom);
				core = CORE_W'($urandom_range(3));
				send_item(req, core);
				if (core < CORE_COUNT) begin
					n++;
				end
			end
		end
		settle();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int b = 0; b < 4; b++) begin
			randomize_schedule();
			test_random_traffic(20);
		end
	endtask

	// Hold the receiver off while the sender keeps offering items.
	task automatic test_backpressure();
		for (int i = 0; i < TB_TASKS; i++) begin
			write_reg(REG_TASK0_SETUP + REG_IDX_W'(i), {1'b1, 16'($urandom), 16'h0000});
		end
		write_reg(REG_CORE1_FIRST, 33'd0);
		write_reg(REG_CORE2_FIRST, 33'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 15; i++) begin
			send_item(REQ_TICK, 2'd2);
			send_item(REQ_RUN,  2'd2);
		end
		settle();
	endtask

	initial begin
		errors        = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		arst_n   <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		for (int t = 0; t < TB_TASKS; t++) begin
			setup_shadow[t] = SETUP_RESET[t];
			countdown[t]    = SETUP_RESET[t][CNT_W-1:0];
		end
		for (int c = 0; c < CORE_COUNT; c++) begin
			tick_flag[c] = 1'b0;
		end
		core1_first = CORE1_FIRST_RESET;
		core2_first = CORE2_FIRST_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 59;
		test_reset_schedule();
		test_extremes();
		test_random_phase(18, 59);
		test_random_phase(59, 18);
		test_random_phase(0, 0);
		test_backpressure();

		settle();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
